// ===== design/dfsj_pkg.sv =====
// ----------------------------------------------------------------------------
// dfsj_pkg
// shared types, constants and helpers of the damped spring force and
// position jacobian unit
// ----------------------------------------------------------------------------
package dfsj_pkg;

    localparam int UNIT_BITS   = 30;
    localparam int SQRT_STAGES = 34;
    localparam int DIV_STAGES  = UNIT_BITS + 1;
    localparam int JAC_ENTRIES = 6;
    localparam int REG_W       = 31;

    localparam logic [40:0] TERM_CLAMP = 41'h100_0000_0000;
    localparam logic signed [32:0] UNIT_ONE = 33'(64'd1 << UNIT_BITS);
    localparam logic signed [67:0] SAT_MAX = 68'sh0_7FFF_FFFF;
    localparam logic signed [67:0] SAT_MIN = -68'sh0_8000_0000;

    // upper triangle of the symmetric 3x3 block: xx xy xz yy yz zz
    localparam int PAIR_ROW [JAC_ENTRIES] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_COL [JAC_ENTRIES] = '{0, 1, 2, 1, 2, 2};

    typedef enum logic [1:0] {
        CFG_REST_LENGTH = 2'd0,
        CFG_STIFFNESS   = 2'd1,
        CFG_DAMPING     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] pos_a_x;
        logic signed [31:0] pos_a_y;
        logic signed [31:0] pos_a_z;
        logic signed [31:0] pos_b_x;
        logic signed [31:0] pos_b_y;
        logic signed [31:0] pos_b_z;
        logic signed [31:0] vel_a_x;
        logic signed [31:0] vel_a_y;
        logic signed [31:0] vel_a_z;
        logic signed [31:0] vel_b_x;
        logic signed [31:0] vel_b_y;
        logic signed [31:0] vel_b_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] jac_xx;
        logic signed [31:0] jac_xy;
        logic signed [31:0] jac_xz;
        logic signed [31:0] jac_yy;
        logic signed [31:0] jac_yz;
        logic signed [31:0] jac_zz;
        logic               tension_active;
    } out_t;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [2:0][41:0] dterm;
    } sqrt_side_t;

    typedef struct packed {
        logic             active;
        logic [2:0]       neg;
        logic [2:0][41:0] dterm;
        logic [63:0]      tens;
    } div_side_t;

    function automatic logic [31:0] sat32(input logic signed [67:0] v);
        logic [31:0] r;
        if (v > SAT_MAX)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [40:0] term_clamp(input logic [94:0] v);
        logic [40:0] r;
        if (v > 95'(TERM_CLAMP))
        begin
            r = TERM_CLAMP;
        end
        else
        begin
            r = v[40:0];
        end
        return r;
    endfunction

endpackage

// ===== design/dfsj_sqrt.sv =====
// ----------------------------------------------------------------------------
// dfsj_sqrt
// pipelined floor square root, one root bit per stage, with sideband
// ----------------------------------------------------------------------------
module dfsj_sqrt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [65:0]            radicand,
    input  dfsj_pkg::sqrt_side_t   in_side,
    output logic                   out_valid,
    output logic [33:0]            root,
    output dfsj_pkg::sqrt_side_t   out_side
);

    localparam int N = dfsj_pkg::SQRT_STAGES;

    logic                 v_reg    [N];
    logic [67:0]          rad_reg  [N];
    logic [35:0]          rem_reg  [N];
    logic [33:0]          root_reg [N];
    dfsj_pkg::sqrt_side_t side_reg [N];

    logic                 v_next    [N];
    logic [67:0]          rad_next  [N];
    logic [35:0]          rem_next  [N];
    logic [33:0]          root_next [N];
    dfsj_pkg::sqrt_side_t side_next [N];

    always_comb
    begin
        logic                 v_src;
        logic [67:0]          rad_src;
        logic [35:0]          rem_src;
        logic [33:0]          root_src;
        dfsj_pkg::sqrt_side_t side_src;
        logic [37:0]          cur;
        logic [37:0]          trial;
        logic [37:0]          diff;
        logic                 ge;
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                v_src    = in_valid;
                rad_src  = {2'b00, radicand};
                rem_src  = '0;
                root_src = '0;
                side_src = in_side;
            end
            else
            begin
                v_src    = v_reg[k-1];
                rad_src  = rad_reg[k-1];
                rem_src  = rem_reg[k-1];
                root_src = root_reg[k-1];
                side_src = side_reg[k-1];
            end
            cur          = {rem_src, rad_src[67:66]};
            trial        = {2'b00, root_src, 2'b01};
            diff         = cur - trial;
            ge           = (cur >= trial);
            v_next[k]    = v_src;
            rad_next[k]  = {rad_src[65:0], 2'b00};
            rem_next[k]  = ge ? diff[35:0] : cur[35:0];
            root_next[k] = {root_src[32:0], ge};
            side_next[k] = side_src;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                v_reg[k] <= v_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign root      = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// ===== design/dfsj_div.sv =====
// ----------------------------------------------------------------------------
// dfsj_div
// pipelined restoring divider, four lanes over one shared divisor,
// quotient (num << unit bits) / den, one quotient bit per stage
// ----------------------------------------------------------------------------
module dfsj_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [3:0][33:0]      num,
    input  logic [33:0]           den,
    input  dfsj_pkg::div_side_t   in_side,
    output logic                  out_valid,
    output logic [3:0][30:0]      quo,
    output dfsj_pkg::div_side_t   out_side
);

    localparam int N = dfsj_pkg::DIV_STAGES;

    logic                v_reg    [N];
    logic [3:0][33:0]    rem_reg  [N];
    logic [3:0][30:0]    quo_reg  [N];
    logic [33:0]         den_reg  [N];
    dfsj_pkg::div_side_t side_reg [N];

    logic                v_next    [N];
    logic [3:0][33:0]    rem_next  [N];
    logic [3:0][30:0]    quo_next  [N];
    logic [33:0]         den_next  [N];
    dfsj_pkg::div_side_t side_next [N];

    always_comb
    begin
        logic                v_src;
        logic [3:0][33:0]    rem_src;
        logic [3:0][30:0]    quo_src;
        logic [33:0]         den_src;
        dfsj_pkg::div_side_t side_src;
        logic [34:0]         cur;
        logic [34:0]         diff;
        logic                ge;
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                v_src    = in_valid;
                rem_src  = num;
                quo_src  = '0;
                den_src  = den;
                side_src = in_side;
            end
            else
            begin
                v_src    = v_reg[k-1];
                rem_src  = rem_reg[k-1];
                quo_src  = quo_reg[k-1];
                den_src  = den_reg[k-1];
                side_src = side_reg[k-1];
            end
            for (int l = 0; l < 4; l++)
            begin
                // first stage takes the numerator as is, later ones shift in zeros
                cur             = (k == 0) ? {1'b0, rem_src[l]} : {rem_src[l], 1'b0};
                diff            = cur - {1'b0, den_src};
                ge              = (cur >= {1'b0, den_src});
                rem_next[k][l]  = ge ? diff[33:0] : cur[33:0];
                quo_next[k][l]  = {quo_src[l][29:0], ge};
            end
            v_next[k]    = v_src;
            den_next[k]  = den_src;
            side_next[k] = side_src;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                v_reg[k] <= v_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                quo_reg[k]  <= quo_next[k];
                den_reg[k]  <= den_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign quo       = quo_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// ===== design/dfsj_skid.sv =====
// ----------------------------------------------------------------------------
// dfsj_skid
// output register with one skid entry; freezes the pipeline only when
// both are full
// ----------------------------------------------------------------------------
module dfsj_skid (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  dfsj_pkg::out_t  in_data,
    output logic            pipe_en,
    output logic            out_valid,
    input  logic            out_stall,
    output dfsj_pkg::out_t  out_data
);

    logic           out_valid_reg;
    logic           skid_valid_reg;
    dfsj_pkg::out_t out_data_reg;
    dfsj_pkg::out_t skid_data_reg;
    logic           out_take;

    assign out_take = out_valid_reg && !out_stall;
    assign pipe_en  = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (in_valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_data_reg <= in_data;
            end
            else
            begin
                out_data_reg <= in_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/damped_spring_force_jacobian_unit.sv =====
// ----------------------------------------------------------------------------
// damped_spring_force_jacobian_unit
// spring force with damping and the symmetric position jacobian block,
// fixed point, fully pipelined
// ----------------------------------------------------------------------------
//  channel  | signals                              | transfer when
//  ---------+--------------------------------------+---------------------------
//  item     | item_valid, item_stall, item         | item_valid && !item_stall
//  result   | result_valid, result_stall, result   | result_valid && !result_stall
//  config   | cfg_wr_en, cfg_index, cfg_data       | cfg_wr_en
//
//  one item per cycle while item_stall is low; the path runs through the
//  34 stage square root and the four lane 31 stage divider
//  reset clears all valid bits and the three registers to zero
//  a stalled result fills one skid entry, then item_stall rises and the
//  whole pipeline holds until the result is taken
// ----------------------------------------------------------------------------
module damped_spring_force_jacobian_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [30:0]      cfg_data,
    input  logic             item_valid,
    output logic             item_stall,
    input  dfsj_pkg::in_t    item,
    output logic             result_valid,
    input  logic             result_stall,
    output dfsj_pkg::out_t   result
);

    localparam int UB = dfsj_pkg::UNIT_BITS;
    localparam int JN = dfsj_pkg::JAC_ENTRIES;

    logic [30:0] rest_length_reg;
    logic [30:0] stiffness_reg;
    logic [30:0] damping_reg;
    logic        pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_length_reg <= '0;
            stiffness_reg   <= '0;
            damping_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                dfsj_pkg::CFG_REST_LENGTH: rest_length_reg <= cfg_data;
                dfsj_pkg::CFG_STIFFNESS:   stiffness_reg   <= cfg_data;
                dfsj_pkg::CFG_DAMPING:     damping_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage a: differences
    logic               a_valid_reg;
    logic signed [32:0] a_dx_reg [3];
    logic signed [32:0] a_dv_reg [3];
    logic signed [32:0] a_dx_next [3];
    logic signed [32:0] a_dv_next [3];

    always_comb
    begin
        a_dx_next[0] = 33'(item.pos_a_x) - 33'(item.pos_b_x);
        a_dx_next[1] = 33'(item.pos_a_y) - 33'(item.pos_b_y);
        a_dx_next[2] = 33'(item.pos_a_z) - 33'(item.pos_b_z);
        a_dv_next[0] = 33'(item.vel_a_x) - 33'(item.vel_b_x);
        a_dv_next[1] = 33'(item.vel_a_y) - 33'(item.vel_b_y);
        a_dv_next[2] = 33'(item.vel_a_z) - 33'(item.vel_b_z);
    end

    // stage b: squares and damping products
    logic        b_valid_reg;
    logic [63:0] b_sq_reg    [3];
    logic [31:0] b_mag_reg   [3];
    logic        b_neg_reg   [3];
    logic [62:0] b_p_reg     [3];
    logic        b_dvneg_reg [3];
    logic [63:0] b_sq_next   [3];
    logic [31:0] b_mag_next  [3];
    logic        b_neg_next  [3];
    logic [62:0] b_p_next    [3];
    logic        b_dvneg_next[3];

    always_comb
    begin
        logic signed [65:0] sq_full;
        logic [32:0]        dxmag;
        logic [32:0]        dvmag;
        for (int i = 0; i < 3; i++)
        begin
            sq_full         = a_dx_reg[i] * a_dx_reg[i];
            dxmag           = a_dx_reg[i][32] ? 33'(-a_dx_reg[i]) : 33'(a_dx_reg[i]);
            dvmag           = a_dv_reg[i][32] ? 33'(-a_dv_reg[i]) : 33'(a_dv_reg[i]);
            b_sq_next[i]    = sq_full[63:0];
            b_mag_next[i]   = dxmag[31:0];
            b_neg_next[i]   = a_dx_reg[i][32];
            b_p_next[i]     = 63'(damping_reg) * 63'(dvmag[31:0]);
            b_dvneg_next[i] = a_dv_reg[i][32];
        end
    end

    // stage c: sum of squares and damping terms
    logic                 c_valid_reg;
    logic [65:0]          c_sum_reg;
    dfsj_pkg::sqrt_side_t c_side_reg;
    logic [65:0]          c_sum_next;
    dfsj_pkg::sqrt_side_t c_side_next;

    always_comb
    begin
        logic [40:0] fd;
        c_sum_next = 66'(b_sq_reg[0]) + 66'(b_sq_reg[1]) + 66'(b_sq_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            fd                   = dfsj_pkg::term_clamp(95'(b_p_reg[i]) >> FRAC_BITS);
            c_side_next.dterm[i] = b_dvneg_reg[i] ? 42'(fd) : -42'(fd);
            c_side_next.mag[i]   = b_mag_reg[i];
            c_side_next.neg[i]   = b_neg_reg[i];
        end
    end

    logic                 s_valid;
    logic [33:0]          s_root;
    dfsj_pkg::sqrt_side_t s_side;

    dfsj_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (c_valid_reg),
        .radicand (c_sum_reg),
        .in_side  (c_side_reg),
        .out_valid(s_valid),
        .root     (s_root),
        .out_side (s_side)
    );

    // stage d: activity and extension
    logic                 d_valid_reg;
    logic [33:0]          d_len_reg;
    logic [33:0]          d_ext_reg;
    logic                 d_active_reg;
    dfsj_pkg::sqrt_side_t d_side_reg;
    logic                 d_active_next;
    logic [33:0]          d_ext_next;

    always_comb
    begin
        d_active_next = (stiffness_reg != '0) && (s_root != '0)
                        && (s_root >= 34'(rest_length_reg));
        d_ext_next    = d_active_next ? (s_root - 34'(rest_length_reg)) : '0;
    end

    // stage e: tension product and divider operands
    logic                e_valid_reg;
    logic [3:0][33:0]    e_num_reg;
    logic [33:0]         e_den_reg;
    dfsj_pkg::div_side_t e_side_reg;
    logic [3:0][33:0]    e_num_next;
    dfsj_pkg::div_side_t e_side_next;

    always_comb
    begin
        logic [64:0] tens_full;
        tens_full          = 65'(stiffness_reg) * 65'(d_ext_reg);
        e_side_next.tens   = tens_full[63:0];
        e_side_next.active = d_active_reg;
        e_side_next.neg    = d_side_reg.neg;
        e_side_next.dterm  = d_side_reg.dterm;
        for (int i = 0; i < 3; i++)
        begin
            e_num_next[i] = 34'(d_side_reg.mag[i]);
        end
        e_num_next[3] = d_ext_reg;
    end

    logic                q_valid;
    logic [3:0][30:0]    q_quo;
    dfsj_pkg::div_side_t q_side;

    dfsj_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (e_valid_reg),
        .num      (e_num_reg),
        .den      (e_den_reg),
        .in_side  (e_side_reg),
        .out_valid(q_valid),
        .quo      (q_quo),
        .out_side (q_side)
    );

    // stage f: unit vector products and force partial products
    logic                f_valid_reg;
    logic [61:0]         f_pmm_reg  [JN];
    logic                f_pneg_reg [JN];
    logic [62:0]         f_flo_reg  [3];
    logic [62:0]         f_fhi_reg  [3];
    logic [30:0]         f_c_reg;
    dfsj_pkg::div_side_t f_side_reg;
    logic [61:0]         f_pmm_next [JN];
    logic                f_pneg_next[JN];
    logic [62:0]         f_flo_next [3];
    logic [62:0]         f_fhi_next [3];

    always_comb
    begin
        for (int k = 0; k < JN; k++)
        begin
            f_pmm_next[k]  = 62'(q_quo[dfsj_pkg::PAIR_ROW[k]])
                             * 62'(q_quo[dfsj_pkg::PAIR_COL[k]]);
            f_pneg_next[k] = q_side.neg[dfsj_pkg::PAIR_ROW[k]]
                             ^ q_side.neg[dfsj_pkg::PAIR_COL[k]];
        end
        for (int i = 0; i < 3; i++)
        begin
            f_flo_next[i] = 63'(q_side.tens[31:0]) * 63'(q_quo[i]);
            f_fhi_next[i] = 63'(q_side.tens[63:32]) * 63'(q_quo[i]);
        end
    end

    // stage g: floored n n^T, identity difference, tension force term
    logic               g_valid_reg;
    logic signed [31:0] g_nn_reg    [JN];
    logic signed [32:0] g_dlt_reg   [JN];
    logic [30:0]        g_c_reg;
    logic signed [41:0] g_tterm_reg [3];
    logic signed [41:0] g_dterm_reg [3];
    logic               g_active_reg;
    logic signed [31:0] g_nn_next   [JN];
    logic signed [32:0] g_dlt_next  [JN];
    logic signed [41:0] g_tterm_next[3];
    logic signed [41:0] g_dterm_next[3];

    always_comb
    begin
        logic signed [62:0] pv;
        logic signed [62:0] pvs;
        logic [94:0]        ffull;
        logic [40:0]        ft;
        for (int k = 0; k < JN; k++)
        begin
            pv            = f_pneg_reg[k] ? -$signed({1'b0, f_pmm_reg[k]})
                                          : $signed({1'b0, f_pmm_reg[k]});
            pvs           = pv >>> UB;
            g_nn_next[k]  = pvs[31:0];
            g_dlt_next[k] = ((dfsj_pkg::PAIR_ROW[k] == dfsj_pkg::PAIR_COL[k])
                             ? dfsj_pkg::UNIT_ONE : 33'sd0) - 33'(g_nn_next[k]);
        end
        for (int i = 0; i < 3; i++)
        begin
            ffull = {f_fhi_reg[i], 32'b0} + 95'(f_flo_reg[i]);
            ft    = dfsj_pkg::term_clamp(ffull >> (FRAC_BITS + UB));
            if (!f_side_reg.active)
            begin
                g_tterm_next[i] = '0;
            end
            else
            begin
                g_tterm_next[i] = f_side_reg.neg[i] ? 42'(ft) : -42'(ft);
            end
            g_dterm_next[i] = $signed(f_side_reg.dterm[i]);
        end
    end

    // stage h: c * (delta - nn) and force sum
    logic               h_valid_reg;
    logic signed [64:0] h_cp_reg   [JN];
    logic signed [31:0] h_nn_reg   [JN];
    logic signed [42:0] h_fsum_reg [3];
    logic               h_active_reg;
    logic signed [64:0] h_cp_next  [JN];
    logic signed [42:0] h_fsum_next[3];

    always_comb
    begin
        for (int k = 0; k < JN; k++)
        begin
            h_cp_next[k] = $signed({1'b0, g_c_reg}) * g_dlt_reg[k];
        end
        for (int i = 0; i < 3; i++)
        begin
            h_fsum_next[i] = 43'(g_tterm_reg[i]) + 43'(g_dterm_reg[i]);
        end
    end

    // stage i: jacobian matrix term
    logic               i_valid_reg;
    logic signed [34:0] i_mm_reg   [JN];
    logic signed [42:0] i_fsum_reg [3];
    logic               i_active_reg;
    logic signed [34:0] i_mm_next  [JN];

    always_comb
    begin
        for (int k = 0; k < JN; k++)
        begin
            i_mm_next[k] = 35'(h_nn_reg[k]) + 35'(h_cp_reg[k] >>> UB);
        end
    end

    // stage j: scale by -stiffness
    logic               j_valid_reg;
    logic signed [67:0] j_jp_reg   [JN];
    logic signed [42:0] j_fsum_reg [3];
    logic               j_active_reg;
    logic signed [67:0] j_jp_next  [JN];

    always_comb
    begin
        logic signed [35:0] negmm;
        for (int k = 0; k < JN; k++)
        begin
            negmm        = -36'(i_mm_reg[k]);
            j_jp_next[k] = $signed({1'b0, stiffness_reg}) * negmm;
        end
    end

    // final saturation into the output register
    dfsj_pkg::out_t res_data;
    logic [31:0]    jac_sat [JN];

    always_comb
    begin
        for (int k = 0; k < JN; k++)
        begin
            jac_sat[k] = j_active_reg ? dfsj_pkg::sat32(j_jp_reg[k] >>> UB) : '0;
        end
        res_data.force_x        = dfsj_pkg::sat32(68'(j_fsum_reg[0]));
        res_data.force_y        = dfsj_pkg::sat32(68'(j_fsum_reg[1]));
        res_data.force_z        = dfsj_pkg::sat32(68'(j_fsum_reg[2]));
        res_data.jac_xx         = jac_sat[0];
        res_data.jac_xy         = jac_sat[1];
        res_data.jac_xz         = jac_sat[2];
        res_data.jac_yy         = jac_sat[3];
        res_data.jac_yz         = jac_sat[4];
        res_data.jac_zz         = jac_sat[5];
        res_data.tension_active = j_active_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
            j_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            a_valid_reg <= item_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= s_valid;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= q_valid;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
            i_valid_reg <= h_valid_reg;
            j_valid_reg <= i_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_dx_reg[i]    <= a_dx_next[i];
                a_dv_reg[i]    <= a_dv_next[i];
                b_sq_reg[i]    <= b_sq_next[i];
                b_mag_reg[i]   <= b_mag_next[i];
                b_neg_reg[i]   <= b_neg_next[i];
                b_p_reg[i]     <= b_p_next[i];
                b_dvneg_reg[i] <= b_dvneg_next[i];
                f_flo_reg[i]   <= f_flo_next[i];
                f_fhi_reg[i]   <= f_fhi_next[i];
                g_tterm_reg[i] <= g_tterm_next[i];
                g_dterm_reg[i] <= g_dterm_next[i];
                h_fsum_reg[i]  <= h_fsum_next[i];
                i_fsum_reg[i]  <= h_fsum_reg[i];
                j_fsum_reg[i]  <= i_fsum_reg[i];
            end
            for (int k = 0; k < JN; k++)
            begin
                f_pmm_reg[k]  <= f_pmm_next[k];
                f_pneg_reg[k] <= f_pneg_next[k];
                g_nn_reg[k]   <= g_nn_next[k];
                g_dlt_reg[k]  <= g_dlt_next[k];
                h_cp_reg[k]   <= h_cp_next[k];
                h_nn_reg[k]   <= g_nn_reg[k];
                i_mm_reg[k]   <= i_mm_next[k];
                j_jp_reg[k]   <= j_jp_next[k];
            end
            c_sum_reg    <= c_sum_next;
            c_side_reg   <= c_side_next;
            d_len_reg    <= s_root;
            d_ext_reg    <= d_ext_next;
            d_active_reg <= d_active_next;
            d_side_reg   <= s_side;
            e_num_reg    <= e_num_next;
            e_den_reg    <= d_len_reg;
            e_side_reg   <= e_side_next;
            f_c_reg      <= q_quo[3];
            f_side_reg   <= q_side;
            g_c_reg      <= f_c_reg;
            g_active_reg <= f_side_reg.active;
            h_active_reg <= g_active_reg;
            i_active_reg <= h_active_reg;
            j_active_reg <= i_active_reg;
        end
    end

    dfsj_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (j_valid_reg),
        .in_data  (res_data),
        .pipe_en  (pipe_en),
        .out_valid(result_valid),
        .out_stall(result_stall),
        .out_data (result)
    );

    assign item_stall = !pipe_en;

endmodule

// ===== verif/dfsj_checker.sv =====
// ----------------------------------------------------------------------------
// dfsj_checker
// watches the item, result and config ports of the damped spring force and
// jacobian unit, computes the expected force and jacobian for every item
// transfer and compares each result transfer with the oldest expectation
// ----------------------------------------------------------------------------
module dfsj_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [30:0]      cfg_data,
    input  logic             item_valid,
    input  logic             item_stall,
    input  dfsj_pkg::in_t    item,
    input  logic             result_valid,
    input  logic             result_stall,
    input  dfsj_pkg::out_t   result,
    output int               fail_count,
    output int               outstanding
);

    localparam int FRAC = 16;
    localparam int UNIT = 30;
    localparam logic [63:0] CLAMP = 64'd1 << 40;

    logic [30:0]    rest_len;
    logic [30:0]    stiff;
    logic [30:0]    damp;
    dfsj_pkg::out_t expected_q [$];

    function automatic logic [31:0] clip32(input longint v);
        logic [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        logic [63:0] r;
        r = (v < 0) ? 64'(-v) : 64'(v);
        return r;
    endfunction

    function automatic dfsj_pkg::out_t spring_response(input dfsj_pkg::in_t it,
                                                       input logic [30:0] rl,
                                                       input logic [30:0] st,
                                                       input logic [30:0] dc);
        longint         dx [3];
        longint         dv [3];
        longint         nv [3];
        longint         frc [3];
        longint         jv [6];
        logic [127:0]   sumsq;
        logic [127:0]   cand;
        logic [127:0]   prod;
        logic [63:0]    len;
        logic [63:0]    ext;
        logic [63:0]    tens;
        logic [63:0]    mg;
        logic [63:0]    um;
        logic [63:0]    fm;
        longint         cf;
        longint         nn;
        longint         mm;
        longint         dl;
        logic           act;
        int             k;
        dfsj_pkg::out_t r;
        dx[0] = longint'(it.pos_a_x) - longint'(it.pos_b_x);
        dx[1] = longint'(it.pos_a_y) - longint'(it.pos_b_y);
        dx[2] = longint'(it.pos_a_z) - longint'(it.pos_b_z);
        dv[0] = longint'(it.vel_a_x) - longint'(it.vel_b_x);
        dv[1] = longint'(it.vel_a_y) - longint'(it.vel_b_y);
        dv[2] = longint'(it.vel_a_z) - longint'(it.vel_b_z);
        sumsq = '0;
        for (int i = 0; i < 3; i++)
        begin
            mg = magnitude(dx[i]);
            sumsq += {64'd0, mg} * {64'd0, mg};
            frc[i] = 0;
            nv[i] = 0;
        end
        for (int i = 0; i < 6; i++)
        begin
            jv[i] = 0;
        end
        len = '0;
        for (int b = 33; b >= 0; b--)
        begin
            cand = {64'd0, len} | (128'd1 << b);
            if (cand * cand <= sumsq)
            begin
                len = cand[63:0];
            end
        end
        act = (st != 0) && (len != 0) && (len >= {33'd0, rl});
        if (act)
        begin
            ext = len - {33'd0, rl};
            tens = {33'd0, st} * ext;
            cf = longint'((ext << UNIT) / len);
            for (int i = 0; i < 3; i++)
            begin
                um = (magnitude(dx[i]) << UNIT) / len;
                nv[i] = (dx[i] < 0) ? -longint'(um) : longint'(um);
                prod = ({64'd0, tens} * {64'd0, um}) >> (FRAC + UNIT);
                fm = (prod > {64'd0, CLAMP}) ? CLAMP : prod[63:0];
                frc[i] = (dx[i] < 0) ? longint'(fm) : -longint'(fm);
            end
            k = 0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = i; j < 3; j++)
                begin
                    nn = (nv[i] * nv[j]) >>> UNIT;
                    dl = (i == j) ? (longint'(1) << UNIT) : 0;
                    mm = nn + ((cf * (dl - nn)) >>> UNIT);
                    jv[k] = (-(longint'(st) * mm)) >>> UNIT;
                    k++;
                end
            end
        end
        if (dc != 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                fm = ({33'd0, dc} * magnitude(dv[i])) >> FRAC;
                if (fm > CLAMP)
                begin
                    fm = CLAMP;
                end
                frc[i] += (dv[i] < 0) ? longint'(fm) : -longint'(fm);
            end
        end
        r.force_x = clip32(frc[0]);
        r.force_y = clip32(frc[1]);
        r.force_z = clip32(frc[2]);
        r.jac_xx = clip32(jv[0]);
        r.jac_xy = clip32(jv[1]);
        r.jac_xz = clip32(jv[2]);
        r.jac_yy = clip32(jv[3]);
        r.jac_yz = clip32(jv[4]);
        r.jac_zz = clip32(jv[5]);
        r.tension_active = act;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %0d (0x%h) actual %0d (0x%h)", name,
                   $signed(exp_v), exp_v, $signed(act_v), act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dfsj_pkg::out_t want;
        if (!rst_n)
        begin
            rest_len <= '0;
            stiff <= '0;
            damp <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    dfsj_pkg::CFG_REST_LENGTH: rest_len <= cfg_data;
                    dfsj_pkg::CFG_STIFFNESS:   stiff <= cfg_data;
                    dfsj_pkg::CFG_DAMPING:     damp <= cfg_data;
                    default:                   ;
                endcase
            end
            if (item_valid && !item_stall)
            begin
                expected_q.push_back(spring_response(item, rest_len, stiff, damp));
            end
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transfer with no expected result");
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("force_x", want.force_x, result.force_x);
                    compare_field("force_y", want.force_y, result.force_y);
                    compare_field("force_z", want.force_z, result.force_z);
                    compare_field("jac_xx", want.jac_xx, result.jac_xx);
                    compare_field("jac_xy", want.jac_xy, result.jac_xy);
                    compare_field("jac_xz", want.jac_xz, result.jac_xz);
                    compare_field("jac_yy", want.jac_yy, result.jac_yy);
                    compare_field("jac_yz", want.jac_yz, result.jac_yz);
                    compare_field("jac_zz", want.jac_zz, result.jac_zz);
                    compare_field("tension_active", 32'(want.tension_active),
                                  32'(result.tension_active));
                end
            end
            outstanding <= expected_q.size();
        end
    end

    initial
    begin
        fail_count = 0;
        outstanding = 0;
    end

endmodule

// ===== verif/tb_damped_spring_force_jacobian_unit.sv =====
// ----------------------------------------------------------------------------
// tb_damped_spring_force_jacobian_unit
// drives directed and random spring items through the unit under several
// register settings with random gaps and result stalls; the checker
// predicts every result and the top reports the verdict
// ----------------------------------------------------------------------------
module tb_damped_spring_force_jacobian_unit;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int PHASES = 7;
    localparam int RANDOM_PER_PHASE = 240;
    localparam int DRAIN_CYCLES = 120;
    localparam longint CYCLE_LIMIT = 400000;

    logic           clk;
    logic           rst_n;
    logic           cfg_wr_en;
    logic [1:0]     cfg_index;
    logic [30:0]    cfg_data;
    logic           item_valid;
    logic           item_stall;
    dfsj_pkg::in_t  item;
    logic           result_valid;
    logic           result_stall;
    dfsj_pkg::out_t result;
    int             fail_count;
    int             outstanding;
    longint         cycles;

    damped_spring_force_jacobian_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    dfsj_checker chk (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .fail_count(fail_count),
        .outstanding(outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stall pattern, switching between four randomly chosen modes
    initial
    begin
        int mode;
        result_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(50, 300))
            begin
                @(negedge clk);
                case (mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 9) < 3);
                    2:       result_stall <= ($urandom_range(0, 9) < 8);
                    default: result_stall <= (cycles % 16) < 5;
                endcase
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one transfer; valid stays high across back to back items
    task automatic send_item(input dfsj_pkg::in_t it, input bit keep_valid);
        @(negedge clk);
        item_valid <= 1'b1;
        item <= it;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        if (!keep_valid)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
    endtask

    function automatic logic [31:0] spread(input logic [31:0] v, input int bits);
        logic [31:0] r;
        r = $signed(v) >>> (32 - bits);
        return r;
    endfunction

    function automatic dfsj_pkg::in_t random_spring();
        dfsj_pkg::in_t it;
        int            sel;
        int            pscale;
        int            vscale;
        sel = $urandom_range(0, 19);
        pscale = $urandom_range(2, 26);
        vscale = $urandom_range(2, 32);
        it.pos_a_x = $urandom;
        it.pos_a_y = $urandom;
        it.pos_a_z = $urandom;
        it.vel_a_x = spread($urandom, vscale);
        it.vel_a_y = spread($urandom, vscale);
        it.vel_a_z = spread($urandom, vscale);
        it.vel_b_x = spread($urandom, vscale);
        it.vel_b_y = spread($urandom, vscale);
        it.vel_b_z = spread($urandom, vscale);
        if (sel < 3)
        begin
            it.pos_b_x = $urandom;
            it.pos_b_y = $urandom;
            it.pos_b_z = $urandom;
            it.vel_a_x = $urandom;
            it.vel_b_z = $urandom;
        end
        else if (sel == 3)
        begin
            it.pos_b_x = it.pos_a_x;
            it.pos_b_y = it.pos_a_y;
            it.pos_b_z = it.pos_a_z;
        end
        else
        begin
            it.pos_b_x = it.pos_a_x + spread($urandom, pscale);
            it.pos_b_y = it.pos_a_y + spread($urandom, pscale);
            it.pos_b_z = it.pos_a_z + spread($urandom, pscale);
        end
        return it;
    endfunction

    function automatic dfsj_pkg::in_t make_item(input logic [31:0] pa,
                                                input logic [31:0] pb,
                                                input logic [31:0] va,
                                                input logic [31:0] vb);
        dfsj_pkg::in_t it;
        it = {pa, pa, pa, pb, pb, pb, va, va, va, vb, vb, vb};
        return it;
    endfunction

    task automatic directed_items();
        send_item(make_item(32'h0, 32'h0, 32'h0, 32'h0), 1'b1);
        send_item(make_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF), 1'b1);
        send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h8000_0000), 1'b1);
        send_item(make_item(32'h0001_2345, 32'h0001_2345, 32'hFFFF_0000,
                            32'h0001_0000), 1'b1);
        send_item(make_item(32'h0000_8000, 32'h0, 32'h0, 32'h0), 1'b1);
        send_item(make_item(32'h0003_0000, 32'h0, 32'h0002_0000, 32'h0), 1'b1);
        send_item(make_item(32'hFFFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF), 1'b1);
        send_item({32'h0001_0000, 32'h0, 32'h0, 96'h0, 192'h0}, 1'b1);
        send_item({32'h0, 32'hFFFD_0000, 32'h0, 96'h0, 32'h0, 32'h7FFF_FFFF,
                   32'h0, 96'h0}, 1'b1);
        send_item({96'h0, 32'h0, 32'h0, 32'h8000_0000, 96'h0, 96'h0}, 1'b0);
    endtask

    initial
    begin
        dfsj_pkg::in_t it;
        int            burst;
        logic [30:0]   r_rest;
        logic [30:0]   r_stiff;
        logic [30:0]   r_damp;
        cycles = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = dfsj_pkg::CFG_REST_LENGTH;
        cfg_data = '0;
        item_valid = 1'b0;
        item = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_items();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    r_rest = 31'h0001_0000;
                    r_stiff = 31'h0001_0000;
                    r_damp = 31'h0001_0000;
                end
                1:
                begin
                    r_rest = 31'h7FFF_FFFF;
                    r_stiff = 31'h7FFF_FFFF;
                    r_damp = 31'h7FFF_FFFF;
                end
                2:
                begin
                    r_rest = '0;
                    r_stiff = 31'h7FFF_FFFF;
                    r_damp = '0;
                end
                3:
                begin
                    r_rest = '0;
                    r_stiff = '0;
                    r_damp = 31'h0000_0001;
                end
                default:
                begin
                    r_rest = $urandom_range(0, 2) == 0 ? 31'($urandom) :
                             31'($urandom_range(0, 32'h0400_0000));
                    r_stiff = $urandom_range(0, 3) == 0 ? 31'($urandom) :
                              31'($urandom_range(1, 32'h0010_0000));
                    r_damp = 31'($urandom) >> $urandom_range(0, 30);
                end
            endcase
            write_reg(dfsj_pkg::CFG_REST_LENGTH, r_rest);
            write_reg(dfsj_pkg::CFG_STIFFNESS, r_stiff);
            write_reg(CFG_UNUSED, 31'($urandom));
            write_reg(dfsj_pkg::CFG_DAMPING, r_damp);
            if (ph == 0)
            begin
                directed_items();
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n += burst)
            begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst; b++)
                begin
                    it = random_spring();
                    if (ph == 1 && b == 0)
                    begin
                        it.pos_b_x = it.pos_a_x;
                        it.pos_b_y = it.pos_a_y;
                        it.pos_b_z = it.pos_a_z;
                    end
                    send_item(it, b != burst - 1);
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    repeat ($urandom_range(0, 10)) @(negedge clk);
                end
            end
        end

        wait_idle();
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
